// ----- hdl/pfsb_pkg.sv -----
// Package for the page-format sprite blitter: screen geometry, bank sizing,
// request codes and the per-request access plan shared by the decoder and the top level.
// Depends on nothing.
`default_nettype none

package pfsb_pkg;

   localparam int SCREEN_COLS  = 128;
   localparam int SCREEN_PAGES = 8;
   localparam int PAGE_BITS    = 8;

   localparam int NUM_BANKS  = 2;
   localparam int BANK_ROWS  = (SCREEN_PAGES + 1) / 2;
   localparam int BANK_DEPTH = BANK_ROWS * SCREEN_COLS;
   localparam int ADDR_W     = $clog2(BANK_DEPTH);

   localparam int CALC_W = 16;

   typedef enum logic {
      FUNC_DRAW = 1'b0,
      FUNC_READ = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WORK
   } state_type;

   typedef struct packed {
      logic                 en;
      logic [ADDR_W-1:0]    addr;
      logic [PAGE_BITS-1:0] bits;
   } bank_op_type;

   typedef struct packed {
      bank_op_type [NUM_BANKS-1:0] op;
      logic                        is_read;
      logic                        rd_ok;
      logic                        rd_bank;
   } plan_type;

endpackage

`default_nettype wire

// ----- hdl/pfsb_channels.sv -----
// Handshake interfaces for the request and response channels of the blitter.
// Depends on nothing.
`default_nettype none

interface pfsb_req_if;
   logic              valid;
   logic              ready;
   logic              func;
   logic signed [8:0] origin_x;
   logic signed [7:0] origin_y;
   logic [2:0]        src_page;
   logic [7:0]        src_col;
   logic [7:0]        pixel_bits;
   logic [2:0]        read_page;
   logic [6:0]        read_col;

   modport source (output valid, func, origin_x, origin_y, src_page, src_col, pixel_bits,
                   read_page, read_col, input ready);
   modport sink (input valid, func, origin_x, origin_y, src_page, src_col, pixel_bits,
                 read_page, read_col, output ready);
endinterface

interface pfsb_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] read_data;

   modport source (output valid, read_data, input ready);
   modport sink (input valid, read_data, output ready);
endinterface

`default_nettype wire

// ----- hdl/pfsb_ram.sv -----
// Generic simple dual-port RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module pfsb_ram #(
   parameter int DEPTH = 512,
   parameter int AW    = 9,
   parameter int DW    = 8
) (
   input  wire logic          clock,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [DW-1:0] rd_data,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ----- hdl/pfsb_decode.sv -----
// Request decoder: works out clipping, page split and bank addresses of a request.
// Depends on pfsb_pkg.
`default_nettype none

module pfsb_decode (
   input  wire logic              func,
   input  wire logic signed [8:0] origin_x,
   input  wire logic signed [7:0] origin_y,
   input  wire logic [2:0]        src_page,
   input  wire logic [7:0]        src_col,
   input  wire logic [7:0]        pixel_bits,
   input  wire logic [2:0]        read_page,
   input  wire logic [6:0]        read_col,
   output pfsb_pkg::plan_type     plan
);

   localparam logic signed [pfsb_pkg::CALC_W-1:0] COLS_S =
      pfsb_pkg::CALC_W'(pfsb_pkg::SCREEN_COLS);
   localparam logic signed [pfsb_pkg::CALC_W-1:0] PAGES_S =
      pfsb_pkg::CALC_W'(pfsb_pkg::SCREEN_PAGES);
   localparam logic [pfsb_pkg::CALC_W-1:0] COLS_U = pfsb_pkg::CALC_W'(pfsb_pkg::SCREEN_COLS);
   localparam logic [pfsb_pkg::CALC_W-1:0] PAGES_U =
      pfsb_pkg::CALC_W'(pfsb_pkg::SCREEN_PAGES);

   logic signed [pfsb_pkg::CALC_W-1:0] col_s;
   logic signed [pfsb_pkg::CALC_W-1:0] page_a;
   logic signed [pfsb_pkg::CALC_W-1:0] page_b;
   logic                               col_ok;
   logic                               page_a_ok;
   logic                               page_b_ok;
   logic [2*pfsb_pkg::PAGE_BITS-1:0]   shifted;
   logic [pfsb_pkg::ADDR_W-1:0]        addr_a;
   logic [pfsb_pkg::ADDR_W-1:0]        addr_b;
   logic [pfsb_pkg::ADDR_W-1:0]        addr_r;
   logic                               is_draw;

   always_comb begin
      col_s  = pfsb_pkg::CALC_W'(origin_x) + pfsb_pkg::CALC_W'($signed({1'b0, src_col}));
      page_a = pfsb_pkg::CALC_W'(origin_y >>> 3) + pfsb_pkg::CALC_W'($signed({1'b0, src_page}));
      page_b = page_a + pfsb_pkg::CALC_W'(1);

      col_ok    = (col_s >= 0) && (col_s < COLS_S);
      page_a_ok = (page_a >= 0) && (page_a < PAGES_S);
      page_b_ok = (page_b >= 0) && (page_b < PAGES_S);

      shifted = {8'h00, pixel_bits} << origin_y[2:0];

      addr_a = pfsb_pkg::ADDR_W'(pfsb_pkg::CALC_W'(page_a[pfsb_pkg::CALC_W-1:1]) * COLS_U
                                 + $unsigned(col_s));
      addr_b = pfsb_pkg::ADDR_W'(pfsb_pkg::CALC_W'(page_b[pfsb_pkg::CALC_W-1:1]) * COLS_U
                                 + $unsigned(col_s));
      addr_r = pfsb_pkg::ADDR_W'(pfsb_pkg::CALC_W'(read_page[2:1]) * COLS_U
                                 + pfsb_pkg::CALC_W'(read_col));

      is_draw      = (func == pfsb_pkg::FUNC_DRAW);
      plan.is_read = (func == pfsb_pkg::FUNC_READ);
      plan.rd_bank = read_page[0];
      plan.rd_ok   = (pfsb_pkg::CALC_W'(read_page) < PAGES_U)
                     && (pfsb_pkg::CALC_W'(read_col) < COLS_U);

      // The first page lands in the bank of its parity and the spill page in the other one.
      for (int b = 0; b < pfsb_pkg::NUM_BANKS; b++) begin
         if (page_a[0] == 1'(b)) begin
            plan.op[b].en   = is_draw && col_ok && page_a_ok
                              && (shifted[pfsb_pkg::PAGE_BITS-1:0] != '0);
            plan.op[b].addr = addr_a;
            plan.op[b].bits = shifted[pfsb_pkg::PAGE_BITS-1:0];
         end else begin
            plan.op[b].en   = is_draw && col_ok && page_b_ok
                              && (shifted[2*pfsb_pkg::PAGE_BITS-1:pfsb_pkg::PAGE_BITS] != '0);
            plan.op[b].addr = addr_b;
            plan.op[b].bits = shifted[2*pfsb_pkg::PAGE_BITS-1:pfsb_pkg::PAGE_BITS];
         end
         if (plan.is_read && (read_page[0] == 1'(b))) begin
            plan.op[b].addr = addr_r;
         end
      end
   end

endmodule

`default_nettype wire

// ----- hdl/page_format_sprite_blit.sv -----
// Top level of the page-format sprite blitter: sequencer, two page-parity RAM banks
// and the response register. Depends on pfsb_pkg, pfsb_channels, pfsb_ram and pfsb_decode.
//
//   Channel   Direction  Holds
//   req_bus   in         func, origin_x, origin_y, src_page, src_col, pixel_bits,
//                        read_page, read_col
//   rsp_bus   out        read_data (one response for each read request)
//
// The banks are read at acceptance and written back or sampled in the next cycle, in
// ST_WORK, so no new request is taken until the sequencer is back in ST_IDLE.
// After reset a clearing pass writes zeros through all BANK_DEPTH addresses of both banks,
// during which no request is accepted.
// A stalled response holds its register; the next request is taken once that slot is free.
`default_nettype none

module page_format_sprite_blit (
   input  wire logic  clock,
   input  wire logic  reset,
   pfsb_req_if.sink   req_bus,
   pfsb_rsp_if.source rsp_bus
);

   pfsb_pkg::state_type state_ff, state_in;
   pfsb_pkg::plan_type  plan_ff, plan_in;
   pfsb_pkg::plan_type  plan_dec;

   logic [pfsb_pkg::ADDR_W-1:0] clr_ff, clr_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [7:0]                  rsp_data_ff, rsp_data_in;
   logic                        accept;

   logic [pfsb_pkg::NUM_BANKS-1:0]                         wr_en;
   logic [pfsb_pkg::NUM_BANKS-1:0][pfsb_pkg::ADDR_W-1:0]   wr_addr;
   logic [pfsb_pkg::NUM_BANKS-1:0][pfsb_pkg::PAGE_BITS-1:0] wr_data;
   logic [pfsb_pkg::NUM_BANKS-1:0][pfsb_pkg::PAGE_BITS-1:0] rd_data;

   pfsb_decode u_decode (
      .func       (req_bus.func),
      .origin_x   (req_bus.origin_x),
      .origin_y   (req_bus.origin_y),
      .src_page   (req_bus.src_page),
      .src_col    (req_bus.src_col),
      .pixel_bits (req_bus.pixel_bits),
      .read_page  (req_bus.read_page),
      .read_col   (req_bus.read_col),
      .plan       (plan_dec)
   );

   for (genvar g = 0; g < pfsb_pkg::NUM_BANKS; g++) begin : g_bank
      pfsb_ram #(
         .DEPTH (pfsb_pkg::BANK_DEPTH),
         .AW    (pfsb_pkg::ADDR_W),
         .DW    (pfsb_pkg::PAGE_BITS)
      ) u_ram (
         .clock   (clock),
         .rd_en   (accept),
         .rd_addr (plan_dec.op[g].addr),
         .rd_data (rd_data[g]),
         .wr_en   (wr_en[g]),
         .wr_addr (wr_addr[g]),
         .wr_data (wr_data[g])
      );
   end

   assign accept            = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid     = rsp_valid_ff;
   assign rsp_bus.read_data = rsp_data_ff;

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      plan_in       = plan_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_data_in   = rsp_data_ff;
      req_bus.ready = 1'b0;

      for (int b = 0; b < pfsb_pkg::NUM_BANKS; b++) begin
         wr_en[b]   = 1'b0;
         wr_addr[b] = plan_ff.op[b].addr;
         wr_data[b] = rd_data[b] | plan_ff.op[b].bits;
      end

      case (state_ff)
         pfsb_pkg::ST_CLEAR: begin
            for (int b = 0; b < pfsb_pkg::NUM_BANKS; b++) begin
               wr_en[b]   = 1'b1;
               wr_addr[b] = clr_ff;
               wr_data[b] = '0;
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == pfsb_pkg::ADDR_W'(pfsb_pkg::BANK_DEPTH - 1)) begin
               state_in = pfsb_pkg::ST_IDLE;
            end
         end
         pfsb_pkg::ST_IDLE: begin
            req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
            if (req_bus.valid && req_bus.ready) begin
               plan_in  = plan_dec;
               state_in = pfsb_pkg::ST_WORK;
            end
         end
         pfsb_pkg::ST_WORK: begin
            for (int b = 0; b < pfsb_pkg::NUM_BANKS; b++) begin
               wr_en[b] = plan_ff.op[b].en;
            end
            if (plan_ff.is_read) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = plan_ff.rd_ok ? rd_data[plan_ff.rd_bank] : '0;
            end
            state_in = pfsb_pkg::ST_IDLE;
         end
         default: begin
            state_in = pfsb_pkg::ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pfsb_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      plan_ff     <= plan_in;
      rsp_data_ff <= rsp_data_in;
   end

   a_accept_to_work: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == pfsb_pkg::ST_WORK))
      else $error("An accepted request did not enter the write-back cycle.");

   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == pfsb_pkg::ST_WORK && plan_ff.is_read))
      else $error("A response appeared without a read request behind it.");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfsb_pkg::ST_IDLE) |-> (wr_en == '0))
      else $error("A bank was written while the sequencer was idle.");

   a_no_accept_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pfsb_pkg::ST_CLEAR) |=> !$past(accept))
      else $error("A request was accepted during the clearing pass.");

endmodule

`default_nettype wire

// ----- bench/pfsb_blit_checker.sv -----
// Checker for the page-format sprite blitter: keeps its own copy of the framebuffer,
// updates it for every accepted draw request and checks every read response in order.
// Depends on pfsb_pkg and the channel interfaces in pfsb_channels.
module pfsb_blit_checker (
   input  wire logic clock,
   input  wire logic reset,
   pfsb_req_if       req_mon,
   pfsb_rsp_if       rsp_mon,
   output int        error_count,
   output int        open_reads
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [7:0] frame_model [pfsb_pkg::SCREEN_PAGES][pfsb_pkg::SCREEN_COLS];
   logic [7:0] read_bytes_due [$];

   function automatic void or_into_frame(int page, int col, logic [7:0] bits);
      if (page >= 0 && page < pfsb_pkg::SCREEN_PAGES && col >= 0
          && col < pfsb_pkg::SCREEN_COLS)
         frame_model[page][col] |= bits;
   endfunction

   function automatic void blit_byte(logic signed [8:0] origin_x, logic signed [7:0] origin_y,
                                     logic [2:0] src_page, logic [7:0] src_col,
                                     logic [7:0] pixel_bits);
      int col;
      int page;
      int shift;
      col   = int'(origin_x) + int'(src_col);
      page  = int'(origin_y >>> 3) + int'(src_page);
      shift = int'(origin_y[2:0]);
      if (pixel_bits == 8'h00 || col < 0 || col >= pfsb_pkg::SCREEN_COLS)
         return;
      or_into_frame(page, col, 8'(pixel_bits << shift));
      if (shift > 0)
         or_into_frame(page + 1, col, 8'(pixel_bits >> (pfsb_pkg::PAGE_BITS - shift)));
   endfunction

   always @(posedge clock) begin : watch
      logic [7:0] due;
      if (reset) begin
         foreach (frame_model[p, c])
            frame_model[p][c] = 8'h00;
         read_bytes_due.delete();
         error_count <= 0;
         open_reads  <= 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (read_bytes_due.size() == 0) begin
               $display("%0t ns: unexpected response, expected none, actual %02h",
                        $time, rsp_mon.read_data);
               error_count <= error_count + 1;
            end else begin
               due = read_bytes_due.pop_front();
               if (rsp_mon.read_data !== due) begin
                  $display("%0t ns: read_data mismatch, expected %02h, actual %02h",
                           $time, due, rsp_mon.read_data);
                  error_count <= error_count + 1;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.func == pfsb_pkg::FUNC_READ)
               read_bytes_due.push_back(frame_model[req_mon.read_page][req_mon.read_col]);
            else
               blit_byte(req_mon.origin_x, req_mon.origin_y, req_mon.src_page,
                         req_mon.src_col, req_mon.pixel_bits);
         end
         open_reads <= read_bytes_due.size();
      end
   end

endmodule

// ----- bench/tb_page_format_sprite_blit.sv -----
// Top of the sprite blitter testbench: clock, reset, directed and random requests and
// a randomly stalling response sink. Depends on pfsb_pkg, pfsb_channels,
// page_format_sprite_blit and pfsb_blit_checker, which does the predicting and comparing.
module tb_page_format_sprite_blit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_REQUESTS = 1750;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int IDLE_PERCENT    = 19;
   localparam int HOLD_OFF_CYCLES = 200;

   typedef struct {
      pfsb_pkg::func_type func;
      logic signed [8:0]  origin_x;
      logic signed [7:0]  origin_y;
      logic [2:0]         src_page;
      logic [7:0]         src_col;
      logic [7:0]         pixel_bits;
      logic [2:0]         read_page;
      logic [6:0]         read_col;
   } blit_request_type;

   logic clock;
   logic reset;
   int   cycles = 0;
   int   sent = 0;
   int   error_count;
   int   open_reads;

   pfsb_req_if req_bus ();
   pfsb_rsp_if rsp_bus ();

   page_format_sprite_blit uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   pfsb_blit_checker frame_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_bus),
      .rsp_mon     (rsp_bus),
      .error_count (error_count),
      .open_reads  (open_reads)
   );

   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Neither side idles while this window of requests goes through.
   function automatic bit steady();
      return sent >= 700 && sent < 1000;
   endfunction

   function automatic blit_request_type make_request(pfsb_pkg::func_type func, int origin_x,
                                                     int origin_y, int src_page, int src_col,
                                                     int pixel_bits, int read_page,
                                                     int read_col);
      blit_request_type r;
      r.func       = func;
      r.origin_x   = 9'(origin_x);
      r.origin_y   = 8'(origin_y);
      r.src_page   = 3'(src_page);
      r.src_col    = 8'(src_col);
      r.pixel_bits = 8'(pixel_bits);
      r.read_page  = 3'(read_page);
      r.read_col   = 7'(read_col);
      return r;
   endfunction

   // Most draws land on or near the screen with small sprite offsets, and many of those set a
   // single bit, so that reads see partly filled bytes rather than saturated ones.
   function automatic blit_request_type random_request();
      blit_request_type r;
      int pick;
      pick         = $urandom_range(0, 99);
      r.func       = (pick < 40) ? pfsb_pkg::FUNC_READ : pfsb_pkg::FUNC_DRAW;
      r.origin_x   = 9'($urandom);
      r.origin_y   = 8'($urandom);
      r.src_page   = 3'($urandom);
      r.src_col    = 8'($urandom);
      r.pixel_bits = 8'($urandom);
      r.read_page  = 3'($urandom);
      r.read_col   = 7'($urandom);
      if (r.func == pfsb_pkg::FUNC_DRAW && pick < 88) begin
         r.origin_x = 9'($urandom_range(0, 143) - 8);
         r.origin_y = 8'($urandom_range(0, 71) - 8);
         r.src_col  = 8'($urandom_range(0, 7));
         r.src_page = 3'($urandom_range(0, 1));
         if (pick < 64)
            r.pixel_bits = 8'(1 << $urandom_range(0, 7));
      end
      if (r.func == pfsb_pkg::FUNC_DRAW && pick >= 96)
         r.pixel_bits = 8'h00;
      return r;
   endfunction

   task automatic offer(input blit_request_type r);
      if (!steady() && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_bus.valid <= 1'b0;
         do
            @(posedge clock);
         while ($urandom_range(0, 99) < IDLE_PERCENT);
      end
      req_bus.valid      <= 1'b1;
      req_bus.func       <= r.func;
      req_bus.origin_x   <= r.origin_x;
      req_bus.origin_y   <= r.origin_y;
      req_bus.src_page   <= r.src_page;
      req_bus.src_col    <= r.src_col;
      req_bus.pixel_bits <= r.pixel_bits;
      req_bus.read_page  <= r.read_page;
      req_bus.read_col   <= r.read_col;
      @(posedge clock);
      while (req_bus.ready !== 1'b1)
         @(posedge clock);
      sent++;
   endtask

   initial begin : response_sink
      int hold_left;
      bit held;
      hold_left = 0;
      held      = 1'b0;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset !== 1'b0)
         @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (!held && sent >= 300) begin
            held      = 1'b1;
            hold_left = HOLD_OFF_CYCLES;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= steady() || $urandom_range(0, 99) >= IDLE_PERCENT;
         end
      end
   end

   initial begin : stimulus
      blit_request_type directed [$];
      reset              <= 1'b1;
      req_bus.valid      <= 1'b0;
      req_bus.func       <= pfsb_pkg::FUNC_DRAW;
      req_bus.origin_x   <= '0;
      req_bus.origin_y   <= '0;
      req_bus.src_page   <= '0;
      req_bus.src_col    <= '0;
      req_bus.pixel_bits <= '0;
      req_bus.read_page  <= '0;
      req_bus.read_col   <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // The first reads carry extreme draw fields and the first draw extreme read fields, as both are ignored.
      directed.push_back(make_request(pfsb_pkg::FUNC_READ, -256, -128, 7, 255, 255, 0, 0));
      directed.push_back(make_request(pfsb_pkg::FUNC_READ, 255, 127, 0, 0, 0, 7, 127));
      directed.push_back(make_request(pfsb_pkg::FUNC_DRAW, 0, 0, 0, 0, 8'hFF, 7, 127));
      directed.push_back(make_request(pfsb_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0));
      directed.push_back(make_request(pfsb_pkg::FUNC_READ, 0, 0, 0, 0, 0, 1, 0));
      directed.push_back(make_request(pfsb_pkg::FUNC_DRAW, 127, 3, 0, 0, 8'hA5, 0, 0));
      directed.push_back(make_request(pfsb_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 127));
      directed.push_back(make_request(pfsb_pkg::FUNC_READ, 0, 0, 0, 0, 0, 1, 127));
      directed.push_back(make_request(pfsb_pkg::FUNC_DRAW, -256, 0, 0, 255, 8'hFF, 0, 0));
      directed.push_back(make_request(pfsb_pkg::FUNC_DRAW, 255, 0, 0, 255, 8'hFF, 0, 0));
      directed.push_back(make_request(pfsb_pkg::FUNC_DRAW, -128, -1, 0, 130, 8'h81, 0, 0));
      directed.push_back(make_request(pfsb_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 2));
      directed.push_back(make_request(pfsb_pkg::FUNC_DRAW, 10, 59, 0, 0, 8'hF0, 0, 0));
      directed.push_back(make_request(pfsb_pkg::FUNC_READ, 0, 0, 0, 0, 0, 7, 10));
      directed.push_back(make_request(pfsb_pkg::FUNC_DRAW, 5, -128, 7, 0, 8'hFF, 0, 0));
      directed.push_back(make_request(pfsb_pkg::FUNC_DRAW, 5, -64, 7, 0, 8'hFF, 0, 0));
      directed.push_back(make_request(pfsb_pkg::FUNC_READ, 0, 0, 0, 0, 0, 7, 5));
      directed.push_back(make_request(pfsb_pkg::FUNC_DRAW, 20, 0, 0, 0, 8'h00, 0, 0));
      directed.push_back(make_request(pfsb_pkg::FUNC_DRAW, 0, 127, 7, 0, 8'hFF, 0, 0));
      directed.push_back(make_request(pfsb_pkg::FUNC_DRAW, 0, 0, 7, 3, 8'h01, 0, 0));
      directed.push_back(make_request(pfsb_pkg::FUNC_READ, 0, 0, 0, 0, 0, 7, 3));
      directed.push_back(make_request(pfsb_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 20));
      foreach (directed[i])
         offer(directed[i]);

      for (int n = 0; n < RANDOM_REQUESTS; n++)
         offer(random_request());
      req_bus.valid <= 1'b0;

      @(posedge clock);
      while (open_reads != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
